@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared property forms used by the allocator rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ design/pfba_pkg.sv @@
// ---------------------------------------------------------------------------
// pfba_pkg
// shared constants, request and status codes, control structs
// ---------------------------------------------------------------------------
package pfba_pkg;

   localparam int BITMAP_WORDS_DEF = 1024;

   localparam int ADDR_W        = 32;
   localparam int PAGE_SHIFT    = 12;
   localparam int BITS_PER_WORD = 32;
   localparam int POS_W         = 5;
   localparam int FRAME_NUM_W   = 15;
   localparam int WIU_W         = 11;
   localparam int TYPE_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int RSP_DATA_W    = 16;

   localparam logic [WIU_W-1:0]         WIU_RESET = 11'd1024;
   localparam logic [BITS_PER_WORD-1:0] FULL_WORD = 32'hFFFF_FFFF;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FIND  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SET   = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd3;

   // response status
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic scan_run;
      logic clear_run;
      logic write_back;
      logic res_load;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic is_find;
      logic out_of_range;
      logic scan_hit;
      logic scan_end;
      logic out_free;
   } sts_type;

endpackage

@@ design/pfba_ctrl.sv @@
// ---------------------------------------------------------------------------
// pfba_ctrl
// request sequencer: clearing pass, lookup, read-modify-write, scan, result
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  pfba_pkg::sts_type sts,
   output pfba_pkg::cmd_type cmd
);
   import pfba_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOOKUP = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_run = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (sts.is_find) begin
               state_in = S_SCAN;
            end else if (sts.out_of_range) begin
               cmd.res_load = 1'b1;
               state_in     = S_RESULT;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.write_back = 1'b1;
            cmd.res_load   = 1'b1;
            state_in       = S_RESULT;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_hit || sts.scan_end) begin
               cmd.res_load = 1'b1;
               state_in     = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_IMPLIES(a_out_load_free, clock, reset, cmd.out_load, sts.out_free)
   `ASSERT_NEXT(a_res_to_result, clock, reset, cmd.res_load, state_ff == S_RESULT)
   `ASSERT_NEXT(a_accept_lookup, clock, reset, req_tvalid && req_tready,
                state_ff == S_LOOKUP)

endmodule

@@ design/pfba_dpath.sv @@
// ---------------------------------------------------------------------------
// pfba_dpath
// bitmap memory, scan counter, result and output registers
// ---------------------------------------------------------------------------
module pfba_dpath #(
   parameter int BITMAP_WORDS = pfba_pkg::BITMAP_WORDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pfba_pkg::ADDR_W-1:0]         req_tdata,
   input  logic [pfba_pkg::TYPE_W-1:0]         req_tuser,
   input  logic                                csr_wen,
   input  logic [pfba_pkg::WIU_W-1:0]          csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pfba_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [pfba_pkg::STATUS_W-1:0]       rsp_tuser,
   input  pfba_pkg::cmd_type                   cmd,
   output pfba_pkg::sts_type                   sts
);
   import pfba_pkg::*;

   localparam int AW      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int CW      = $clog2(BITMAP_WORDS + 1);
   localparam int CMP_W   = 16;
   localparam int FRAME_W = ADDR_W - PAGE_SHIFT;
   localparam int WORD_W  = FRAME_W - POS_W;
   localparam logic [AW-1:0] LAST_WORD = AW'(BITMAP_WORDS - 1);

   function automatic logic [POS_W-1:0] lowest_zero(input logic [BITS_PER_WORD-1:0] w);
      logic [BITS_PER_WORD-1:0] onehot;
      logic [POS_W-1:0]         idx;
      onehot = ~w & (w + BITS_PER_WORD'(1));
      idx    = '0;
      for (int j = 0; j < BITS_PER_WORD; j++) begin
         if (onehot[j]) begin
            idx = idx | POS_W'(j);
         end
      end
      return idx;
   endfunction

   logic [BITS_PER_WORD-1:0] mem [BITMAP_WORDS];

   logic [WIU_W-1:0]         wiu_ff;
   logic [TYPE_W-1:0]        type_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [BITS_PER_WORD-1:0] rd_data_ff;
   logic                     chk_valid_ff;
   logic [AW-1:0]            chk_idx_ff;
   logic [CW-1:0]            scan_cnt_ff;
   logic [CW-1:0]            scan_cnt_in;
   logic [AW-1:0]            clr_cnt_ff;
   logic                     res_bit_ff;
   logic [FRAME_NUM_W-1:0]   res_frame_ff;
   logic [STATUS_W-1:0]      res_status_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic                     out_bit_ff;
   logic [FRAME_NUM_W-1:0]   out_frame_ff;
   logic [STATUS_W-1:0]      out_status_ff;

   logic [FRAME_W-1:0]       frame;
   logic [WORD_W-1:0]        word;
   logic [POS_W-1:0]         pos;
   logic                     out_of_range;
   logic [CW-1:0]            limit;
   logic                     issue;
   logic                     hit;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [BITS_PER_WORD-1:0] wr_data;
   logic [BITS_PER_WORD-1:0] mask;
   logic [BITS_PER_WORD-1:0] modified;
   logic                     is_find;
   logic                     is_write;
   logic [FRAME_NUM_W-1:0]   find_frame;

   // address split
   assign frame        = addr_ff[ADDR_W-1:PAGE_SHIFT];
   assign word         = frame[FRAME_W-1:POS_W];
   assign pos          = frame[POS_W-1:0];
   assign out_of_range = {1'b0, word} >= CMP_W'(BITMAP_WORDS);
   assign is_find      = (type_ff == REQ_FIND);
   assign is_write     = (type_ff == REQ_SET) || (type_ff == REQ_CLEAR);

   // search length clamped to the bitmap size
   assign limit = (CMP_W'(wiu_ff) > CMP_W'(BITMAP_WORDS)) ? CW'(BITMAP_WORDS) : CW'(wiu_ff);
   assign issue = cmd.scan_run && (scan_cnt_ff < limit);
   assign hit   = chk_valid_ff && (rd_data_ff != FULL_WORD);

   assign scan_cnt_in = cmd.start ? '0 : (issue ? scan_cnt_ff + CW'(1) : scan_cnt_ff);

   // memory ports
   assign rd_addr  = cmd.scan_run ? scan_cnt_ff[AW-1:0] : word[AW-1:0];
   assign mask     = BITS_PER_WORD'(1) << pos;
   assign modified = (type_ff == REQ_SET) ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
   assign wr_en    = cmd.clear_run || (cmd.write_back && is_write);
   assign wr_addr  = cmd.clear_run ? clr_cnt_ff : word[AW-1:0];
   assign wr_data  = cmd.clear_run ? '0 : modified;

   assign find_frame = FRAME_NUM_W'({chk_idx_ff, lowest_zero(rd_data_ff)});

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wiu_ff       <= WIU_RESET;
         clr_cnt_ff   <= '0;
         scan_cnt_ff  <= '0;
         chk_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            wiu_ff <= csr_wdata;
         end
         if (cmd.clear_run) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         scan_cnt_ff  <= scan_cnt_in;
         chk_valid_ff <= issue;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      chk_idx_ff <= scan_cnt_ff[AW-1:0];
      if (cmd.start) begin
         type_ff <= req_tuser;
         addr_ff <= req_tdata;
      end
      if (cmd.res_load) begin
         if (is_find) begin
            res_bit_ff    <= 1'b0;
            res_frame_ff  <= hit ? find_frame : '0;
            res_status_ff <= hit ? ST_OK : ST_NOFREE;
         end else if (out_of_range) begin
            res_bit_ff    <= 1'b0;
            res_frame_ff  <= frame[FRAME_NUM_W-1:0];
            res_status_ff <= ST_RANGE;
         end else begin
            res_bit_ff    <= rd_data_ff[pos];
            res_frame_ff  <= frame[FRAME_NUM_W-1:0];
            res_status_ff <= ST_OK;
         end
      end
      if (cmd.out_load) begin
         out_bit_ff    <= res_bit_ff;
         out_frame_ff  <= res_frame_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_frame_ff, out_bit_ff};
   assign rsp_tuser  = out_status_ff;

   // scan end is only looked at while scanning, so it needs no command term
   assign sts.clear_done   = (clr_cnt_ff == LAST_WORD);
   assign sts.is_find      = is_find;
   assign sts.out_of_range = out_of_range;
   assign sts.scan_hit     = hit;
   assign sts.scan_end     = !chk_valid_ff && !(scan_cnt_ff < limit);
   assign sts.out_free     = !out_valid_ff || rsp_tready;

endmodule

@@ design/page_frame_bitmap_allocator.sv @@
// query, mark used, mark free: lookup reads the word, check writes back a changed word and
// loads the result, result moves it to the response register; beyond the bitmap lookup
// loads it; find scans up to min(words_in_use, BITMAP_WORDS) words, one word per cycle on
// the bitmap read port, until one has a free bit; the response register lets the next
// request in while a response waits to be taken; reset is synchronous, active high; then
// a clearing pass zeroes the bitmap (every frame free); req_tready stays low until it ends
// ---------------------------------------------------------------------------
// page_frame_bitmap_allocator
// bitmap page frame allocator: query, find lowest free, mark used, mark free
// ---------------------------------------------------------------------------
module page_frame_bitmap_allocator #(
   parameter int BITMAP_WORDS = pfba_pkg::BITMAP_WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pfba_pkg::ADDR_W-1:0]     req_tdata,  // [31:0] phys_addr
   input  logic [pfba_pkg::TYPE_W-1:0]     req_tuser,  // [1:0] req_type
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pfba_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [0] frame_bit, [15:1] frame_no
   output logic [pfba_pkg::STATUS_W-1:0]   rsp_tuser,  // [1:0] status
   // search length register
   input  logic                            csr_wen,
   input  logic [pfba_pkg::WIU_W-1:0]      csr_wdata   // [10:0] words_in_use
);
   import pfba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: clearing pass, then one request at a time through
   // lookup / read-modify-write or the word-by-word scan
   pfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // bitmap memory with registered read, scan pipeline and response register
   pfba_dpath #(
      .BITMAP_WORDS (BITMAP_WORDS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
